// File: rtl/acfr_pkg.sv
// Package for the ASCII frame checker and responder.
// Character codes, command selectors, reply payload kinds and helper functions.
// No dependencies.
package acfr_pkg;

    localparam int MAX_FRAME   = 64;
    localparam int STORE_DEPTH = 22;
    localparam int HDR_LEN     = 10;
    localparam int MIN_FRAME   = 12;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_D    = 8'h44;

    // second character of the command field; the third is always CMD_TAIL
    localparam logic [7:0] CMD_TAIL    = 8'h31;
    localparam logic [7:0] CMD_SEL_D01 = 8'h30;
    localparam logic [7:0] CMD_SEL_D11 = 8'h31;
    localparam logic [7:0] CMD_SEL_D21 = 8'h32;
    localparam logic [7:0] CMD_SEL_D31 = 8'h33;
    localparam logic [7:0] CMD_SEL_D41 = 8'h34;
    localparam logic [7:0] CMD_SEL_D51 = 8'h35;
    localparam logic [7:0] CMD_SEL_D61 = 8'h36;
    localparam logic [7:0] CMD_SEL_D71 = 8'h37;
    localparam logic [7:0] CMD_SEL_D81 = 8'h38;

    typedef enum logic [1:0] {
        PL_DATA01,
        PL_DATA81,
        PL_OK,
        PL_NO
    } t_payload;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib <= 4'd9) ? {4'h0, nib} + 8'h30 : {4'h0, nib} + 8'h37;
    endfunction

    // '0'..'9', 'A'..'Z', 'a'..'z'; anything else is zero
    function automatic logic [5:0] digit_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'd48 && c <= 8'd57) begin
            v = c - 8'd48;
        end else if (c >= 8'd65 && c <= 8'd90) begin
            v = c - 8'd55;
        end else if (c >= 8'd97 && c <= 8'd122) begin
            v = c - 8'd87;
        end
        return v[5:0];
    endfunction

    function automatic logic [7:0] payload_byte(input t_payload kind, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (kind)
            PL_DATA01, PL_DATA81: begin
                unique case (idx)
                    3'd0, 3'd1, 3'd2: c = 8'h30;
                    3'd3:             c = 8'h33;
                    3'd4:             c = 8'h41;
                    default:          c = (kind == PL_DATA01) ? 8'h42 : 8'h33;
                endcase
            end
            PL_OK: c = (idx == 3'd0) ? 8'h4F : 8'h4B;
            PL_NO: c = (idx == 3'd0) ? 8'h4E : 8'h4F;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/acfr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module acfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 22
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/ascii_frame_checker_responder_unit.sv
// Top level of the ASCII frame checker and responder.
// Uses acfr_pkg and one acfr_ram instance for the frame store.
//
// Receive channel (i_rx_valid / o_rx_ready / i_rx_byte): one byte per
// transfer, one a cycle while a frame is collected. Line feeds are dropped;
// a carriage return closes the frame.
// Reply channel (o_reply_valid / i_reply_ready / o_reply_byte,
// o_reply_last): 16 or 20 bytes for an accepted frame, o_reply_last on the LF.
// A CR that passes length and checksum drops o_rx_ready while bytes 4 to
// 21 are scanned (one RAM read a cycle) and the command decided. The reply
// follows: each header byte waits for its RAM read, each payload and
// trailer byte loads as soon as the output slot is free, and o_rx_ready
// returns once the LF is loaded, later if the receiver stalls. A frame
// failing length or checksum leaves o_rx_ready high; one failing the ID or
// command check releases the receive side after the scan and decide states.
// The final reply byte sits in the output register while the next frame
// is already being received.
// Reset: frame state cleared, device ID set to "000", output empty. The
// frame store is not swept; a fill count masks entries not yet written.
module ascii_frame_checker_responder_unit #(
    parameter int MAX_FRAME = acfr_pkg::MAX_FRAME
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_reply_valid,
    input  logic       i_reply_ready,
    output logic [7:0] o_reply_byte,
    output logic       o_reply_last
);

    localparam int ADDR_W = $clog2(acfr_pkg::STORE_DEPTH);

    typedef enum logic [1:0] {
        S_RX,
        S_SCAN,
        S_DECIDE,
        S_SEND
    } t_state;

    t_state r_state;

    // receive-side frame state
    logic [6:0] r_len;
    logic [7:0] r_rsum;
    logic [7:0] r_lag0, r_lag1;
    logic       r_ovf;
    logic [7:0] r_dev_id [3];

    // scan state
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_pidx;
    logic              r_pvalid;
    logic [7:0]        r_cmd [3];
    logic [7:0]        r_new_id [3];
    logic              r_id_ok;
    logic [19:0]       r_acc;
    logic [2:0]        r_nz, r_nf;

    // reply state
    acfr_pkg::t_payload r_kind;
    logic [2:0]         r_plen;
    logic [4:0]         r_pos;
    logic               r_fetched;
    logic [7:0]         r_csum;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    // RAM
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;

    logic rx_take;
    logic is_lf, is_cr, ck_ok, frame_ok;

    assign rx_take = i_rx_valid && (r_state == S_RX);
    assign is_lf   = (i_rx_byte == acfr_pkg::CH_LF);
    assign is_cr   = (i_rx_byte == acfr_pkg::CH_CR);
    assign ck_ok   = (acfr_pkg::hex_char(r_rsum[7:4]) == r_lag0) &&
                     (acfr_pkg::hex_char(r_rsum[3:0]) == r_lag1);
    assign frame_ok = !r_ovf && (r_len >= 7'(acfr_pkg::MIN_FRAME)) && ck_ok;

    assign ram_wr_en = rx_take && !is_lf && !is_cr && !r_ovf &&
                       (r_len < 7'(MAX_FRAME)) &&
                       (r_len < 7'(acfr_pkg::STORE_DEPTH));

    always_comb begin
        ram_rd_addr = '0;
        if (r_state == S_SEND) begin
            if (r_pos < 5'(acfr_pkg::HDR_LEN)) begin
                ram_rd_addr = ADDR_W'(r_pos);
            end
        end else if ({2'b00, r_idx} < 7'(acfr_pkg::STORE_DEPTH)) begin
            ram_rd_addr = r_idx;
        end
    end

    acfr_ram #(
        .WIDTH (8),
        .DEPTH (acfr_pkg::STORE_DEPTH)
    ) u_frame_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_len[ADDR_W-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // scan datapath: bytes past the frame end read as zero
    logic [7:0]  scan_byte;
    logic [5:0]  scan_digit;
    logic [19:0] n_acc;
    logic [1:0]  grp;
    logic [1:0]  id_sel;

    always_comb begin
        scan_byte  = ({2'b00, r_pidx} < r_len) ? ram_rd_data : 8'h00;
        scan_digit = acfr_pkg::digit_val(scan_byte);
        if (r_pidx[1:0] == 2'b10) begin
            n_acc = {14'h0, scan_digit};
        end else if (r_pidx < ADDR_W'(14)) begin
            n_acc = {r_acc[15:0], 4'h0} | {14'h0, scan_digit};
        end else begin
            n_acc = {r_acc[15:0], 4'h0} + {14'h0, scan_digit};
        end
        if (r_pidx < ADDR_W'(14)) begin
            grp = 2'd0;
        end else if (r_pidx < ADDR_W'(18)) begin
            grp = 2'd1;
        end else begin
            grp = 2'd2;
        end
        id_sel = 2'(r_pidx - ADDR_W'(7));
    end

    // command decode
    logic               cmd_known, cmd_set_id;
    acfr_pkg::t_payload cmd_kind;
    logic [2:0]         cmd_plen;

    always_comb begin
        cmd_known  = (r_cmd[0] == acfr_pkg::CH_D) && (r_cmd[2] == acfr_pkg::CMD_TAIL);
        cmd_set_id = 1'b0;
        cmd_kind   = acfr_pkg::PL_OK;
        cmd_plen   = 3'd2;
        unique case (r_cmd[1])
            acfr_pkg::CMD_SEL_D01: begin
                cmd_kind = acfr_pkg::PL_DATA01;
                cmd_plen = 3'd6;
            end
            acfr_pkg::CMD_SEL_D81: begin
                cmd_kind = acfr_pkg::PL_DATA81;
                cmd_plen = 3'd6;
            end
            acfr_pkg::CMD_SEL_D11, acfr_pkg::CMD_SEL_D21, acfr_pkg::CMD_SEL_D41,
            acfr_pkg::CMD_SEL_D51, acfr_pkg::CMD_SEL_D61: begin
                cmd_kind = acfr_pkg::PL_OK;
            end
            acfr_pkg::CMD_SEL_D31: begin
                cmd_set_id = cmd_known;
            end
            acfr_pkg::CMD_SEL_D71: begin
                cmd_kind = ((&r_nz) || (&r_nf)) ? acfr_pkg::PL_OK : acfr_pkg::PL_NO;
            end
            default: cmd_known = 1'b0;
        endcase
    end

    // reply byte generator
    logic       slot_free;
    logic       out_load;
    logic [4:0] off, tail;
    logic [7:0] gen_byte;
    logic       gen_sum, gen_last;

    assign slot_free = !r_out_valid || i_reply_ready;
    assign out_load  = (r_state == S_SEND) && slot_free &&
                       !((r_pos < 5'(acfr_pkg::HDR_LEN)) && !r_fetched);

    always_comb begin
        off      = r_pos - 5'(acfr_pkg::HDR_LEN);
        tail     = off - {2'b00, r_plen};
        gen_sum  = 1'b1;
        gen_last = 1'b0;
        if (r_pos < 5'(acfr_pkg::HDR_LEN)) begin
            gen_byte = ram_rd_data;
        end else if (off < {2'b00, r_plen}) begin
            gen_byte = acfr_pkg::payload_byte(r_kind, off[2:0]);
        end else begin
            gen_sum = 1'b0;
            unique case (tail[1:0])
                2'd0: gen_byte = acfr_pkg::hex_char(r_csum[7:4]);
                2'd1: gen_byte = acfr_pkg::hex_char(r_csum[3:0]);
                2'd2: gen_byte = acfr_pkg::CH_CR;
                2'd3: begin
                    gen_byte = acfr_pkg::CH_LF;
                    gen_last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RX;
            r_len       <= '0;
            r_rsum      <= '0;
            r_lag0      <= '0;
            r_lag1      <= '0;
            r_ovf       <= 1'b0;
            r_dev_id[0] <= acfr_pkg::CH_ZERO;
            r_dev_id[1] <= acfr_pkg::CH_ZERO;
            r_dev_id[2] <= acfr_pkg::CH_ZERO;
            r_idx       <= '0;
            r_pidx      <= '0;
            r_pvalid    <= 1'b0;
            r_kind      <= acfr_pkg::PL_OK;
            r_plen      <= 3'd2;
            r_pos       <= '0;
            r_fetched   <= 1'b0;
            r_csum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && !i_reply_ready);
            unique case (r_state)
                S_RX: begin
                    if (rx_take && !is_lf) begin
                        if (is_cr) begin
                            if (frame_ok) begin
                                r_state  <= S_SCAN;
                                r_idx    <= ADDR_W'(4);
                                r_pvalid <= 1'b0;
                                r_id_ok  <= 1'b1;
                            end else begin
                                r_len  <= '0;
                                r_rsum <= '0;
                                r_lag0 <= '0;
                                r_lag1 <= '0;
                                r_ovf  <= 1'b0;
                            end
                        end else if (!r_ovf) begin
                            if (r_len >= 7'(MAX_FRAME)) begin
                                r_ovf <= 1'b1;
                            end else begin
                                if (r_len >= 7'd2) begin
                                    r_rsum <= r_rsum + r_lag0;
                                end
                                r_lag0 <= r_lag1;
                                r_lag1 <= i_rx_byte;
                                r_len  <= r_len + 7'd1;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_idx    <= r_idx + ADDR_W'(1);
                    r_pidx   <= r_idx;
                    r_pvalid <= 1'b1;
                    if (r_pvalid) begin
                        if (r_pidx < ADDR_W'(7)) begin
                            r_cmd[2'(r_pidx - ADDR_W'(4))] <= scan_byte;
                        end else if (r_pidx < ADDR_W'(10)) begin
                            if (scan_byte != r_dev_id[id_sel]) begin
                                r_id_ok <= 1'b0;
                            end
                        end else begin
                            if (r_pidx < ADDR_W'(13)) begin
                                r_new_id[2'(r_pidx - ADDR_W'(10))] <= scan_byte;
                            end
                            r_acc <= n_acc;
                            if (r_pidx[1:0] == 2'b01) begin
                                r_nz[grp] <= (n_acc != 20'h0);
                                r_nf[grp] <= (n_acc != 20'h0FFFF);
                            end
                        end
                        if (r_pidx == ADDR_W'(acfr_pkg::STORE_DEPTH - 1)) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_len  <= '0;
                    r_rsum <= '0;
                    r_lag0 <= '0;
                    r_lag1 <= '0;
                    r_ovf  <= 1'b0;
                    if (cmd_known && r_id_ok) begin
                        r_state   <= S_SEND;
                        r_kind    <= cmd_kind;
                        r_plen    <= cmd_plen;
                        r_pos     <= '0;
                        r_fetched <= 1'b0;
                        r_csum    <= '0;
                        if (cmd_set_id) begin
                            r_dev_id[0] <= r_new_id[0];
                            r_dev_id[1] <= r_new_id[1];
                            r_dev_id[2] <= r_new_id[2];
                        end
                    end else begin
                        r_state <= S_RX;
                    end
                end
                S_SEND: begin
                    if ((r_pos < 5'(acfr_pkg::HDR_LEN)) && !r_fetched) begin
                        // header byte: wait for the RAM read
                        r_fetched <= 1'b1;
                    end else if (slot_free) begin
                        r_out_byte  <= gen_byte;
                        r_out_last  <= gen_last;
                        r_pos       <= r_pos + 5'd1;
                        r_fetched   <= 1'b0;
                        if (gen_sum) begin
                            r_csum <= r_csum + gen_byte;
                        end
                        if (gen_last) begin
                            r_state <= S_RX;
                        end
                    end
                end
            endcase
        end
    end

    assign o_rx_ready    = (r_state == S_RX);
    assign o_reply_valid = r_out_valid;
    assign o_reply_byte  = r_out_byte;
    assign o_reply_last  = r_out_last;

`ifndef SYNTHESIS
    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_byte == acfr_pkg::CH_LF))
        else $error("reply_last on a byte other than LF");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= 7'(MAX_FRAME))
        else $error("frame length beyond limit");

    a_ovf_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == 7'(MAX_FRAME)))
        else $error("overflow mark without full length");

    a_send_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> (r_pos < 5'd20))
        else $error("reply position past end of reply");
`endif

endmodule

// File: dv/ascii_frame_checker_responder_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for ascii_frame_checker_responder_unit: a directed
// frame table, then random frames; each reply byte checked against the table row or a local model.
// Depends on acfr_pkg and the RTL top level.
module ascii_frame_checker_responder_unit_tb;

    localparam int FRAME_LIMIT  = acfr_pkg::MAX_FRAME;
    localparam int RANDOM_BYTES = 100;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PRINT_LIMIT  = 100;

    typedef logic [7:0] t_bytes [$];
    typedef enum {CK_GOOD, CK_BAD, CK_NONE} t_ck;
    typedef enum {EXP_MODEL, EXP_NONE, EXP_TYPED} t_exp;
    typedef struct {
        string body;
        int    pad;
        t_ck   ck;
        t_exp  exp;
        string payload;
    } t_frame_row;
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_reply;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_rx_valid    = 1'b0;
    logic [7:0] i_rx_byte     = 8'h00;
    logic       i_reply_ready = 1'b0;
    logic       o_rx_ready;
    logic       o_reply_valid;
    logic [7:0] o_reply_byte;
    logic       o_reply_last;

    // model of the checker
    logic [7:0] fr_store [acfr_pkg::STORE_DEPTH];
    logic [6:0] fr_len;
    logic [7:0] fr_sum;
    logic [7:0] fr_lag [2];
    logic       fr_ovf;
    logic [7:0] dev_id [3];
    bit         model_muted;

    t_reply     reply_due_q [$];
    t_reply     seen_due;
    t_frame_row frame_table [$];
    int         err_count   = 0;
    int         idle_cycles = 0;
    int         burst_left  = 0;
    bit         steady      = 1'b0;
    int         rx_sent     = 0;
    logic [7:0] ready_pat   = 8'hFF;
    int         pat_age     = 0;

    ascii_frame_checker_responder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .o_reply_valid (o_reply_valid),
        .i_reply_ready (i_reply_ready),
        .o_reply_byte  (o_reply_byte),
        .o_reply_last  (o_reply_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [7:0] nib_ascii(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h37 + {4'h0, n};
    endfunction

    function automatic logic [31:0] digit_weight(input logic [7:0] c);
        if (c >= 8'd48 && c <= 8'd57) return 32'(c - 8'd48);
        if (c >= 8'd65 && c <= 8'd90) return 32'(c - 8'd55);
        if (c >= 8'd97 && c <= 8'd122) return 32'(c - 8'd87);
        return 32'd0;
    endfunction

    // line feeds never reach the running sum, so they are left out here too
    function automatic logic [7:0] byte_sum(input t_bytes q);
        logic [7:0] s;
        s = 8'h00;
        foreach (q[k]) begin
            if (q[k] != acfr_pkg::CH_LF) s += q[k];
        end
        return s;
    endfunction

    function automatic void seal_and_queue(input t_bytes rep);
        logic [7:0] s;
        t_reply     r;
        s = byte_sum(rep);
        rep.push_back(nib_ascii(s[7:4]));
        rep.push_back(nib_ascii(s[3:0]));
        rep.push_back(acfr_pkg::CH_CR);
        rep.push_back(acfr_pkg::CH_LF);
        foreach (rep[k]) begin
            r.data = rep[k];
            r.last = (k == rep.size() - 1);
            reply_due_q.push_back(r);
        end
    endfunction

    function automatic void clear_frame();
        foreach (fr_store[k]) fr_store[k] = 8'h00;
        fr_len    = '0;
        fr_sum    = '0;
        fr_lag[0] = '0;
        fr_lag[1] = '0;
        fr_ovf    = 1'b0;
    endfunction

    function automatic void close_frame();
        string       pl_txt;
        t_bytes      rep;
        logic [31:0] v [3];
        if (fr_ovf || fr_len < acfr_pkg::MIN_FRAME) return;
        if (nib_ascii(fr_sum[7:4]) != fr_lag[0] || nib_ascii(fr_sum[3:0]) != fr_lag[1])
            return;
        if (fr_store[7] != dev_id[0] || fr_store[8] != dev_id[1] || fr_store[9] != dev_id[2])
            return;
        if (fr_store[4] != acfr_pkg::CH_D || fr_store[6] != acfr_pkg::CMD_TAIL) return;
        case (fr_store[5])
            acfr_pkg::CMD_SEL_D01: pl_txt = "0003AB";
            acfr_pkg::CMD_SEL_D81: pl_txt = "0003A3";
            acfr_pkg::CMD_SEL_D11, acfr_pkg::CMD_SEL_D21, acfr_pkg::CMD_SEL_D41,
            acfr_pkg::CMD_SEL_D51, acfr_pkg::CMD_SEL_D61: pl_txt = "OK";
            acfr_pkg::CMD_SEL_D31: begin
                dev_id[0] = fr_store[10];
                dev_id[1] = fr_store[11];
                dev_id[2] = fr_store[12];
                pl_txt = "OK";
            end
            acfr_pkg::CMD_SEL_D71: begin
                // first value ORs its digits in, the other two add them
                v[0] = digit_weight(fr_store[10]);
                for (int k = 11; k < 14; k++) v[0] = (v[0] << 4) | digit_weight(fr_store[k]);
                for (int g = 1; g < 3; g++) begin
                    v[g] = digit_weight(fr_store[10 + 4 * g]);
                    for (int j = 1; j < 4; j++)
                        v[g] = (v[g] << 4) + digit_weight(fr_store[10 + 4 * g + j]);
                end
                if ((v[0] != 0 && v[1] != 0 && v[2] != 0) ||
                    (v[0] != 32'hFFFF && v[1] != 32'hFFFF && v[2] != 32'hFFFF))
                    pl_txt = "OK";
                else
                    pl_txt = "NO";
            end
            default: return;
        endcase
        for (int k = 0; k < acfr_pkg::HDR_LEN; k++) rep.push_back(fr_store[k]);
        for (int k = 0; k < pl_txt.len(); k++) rep.push_back(pl_txt[k]);
        if (!model_muted) seal_and_queue(rep);
    endfunction

    function automatic void absorb_rx_byte(input logic [7:0] b);
        if (b == acfr_pkg::CH_LF) return;
        if (b == acfr_pkg::CH_CR) begin
            close_frame();
            clear_frame();
            return;
        end
        if (fr_ovf) return;
        if (fr_len >= FRAME_LIMIT) begin
            fr_ovf = 1'b1;
            return;
        end
        if (fr_len < acfr_pkg::STORE_DEPTH) fr_store[fr_len] = b;
        if (fr_len >= 2) fr_sum += fr_lag[0];
        fr_lag[0] = fr_lag[1];
        fr_lag[1] = b;
        fr_len++;
    endfunction

    function automatic t_bytes close_with_check(input t_bytes q, input t_ck ck);
        logic [7:0] s;
        s = byte_sum(q);
        if (ck == CK_BAD) s = s + 8'($urandom_range(1, 255));
        if (ck != CK_NONE) begin
            q.push_back(nib_ascii(s[7:4]));
            q.push_back(nib_ascii(s[3:0]));
        end
        q.push_back(acfr_pkg::CH_CR);
        return q;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == acfr_pkg::CH_CR || b == acfr_pkg::CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] digit_char();
        string digits;
        digits = "0123456789ABCDEFGZabcfz";
        return digits[$urandom_range(0, digits.len() - 1)];
    endfunction

    function automatic t_bytes random_frame();
        t_bytes     q;
        int         plen;
        logic [7:0] sel;
        if ($urandom_range(0, 99) < 8) begin
            // noise, may hold stray CRs and LFs
            repeat ($urandom_range(0, 20)) q.push_back(8'($urandom));
            q.push_back(acfr_pkg::CH_CR);
            return q;
        end
        repeat (4) q.push_back(plain_byte());
        case ($urandom_range(0, 13))
            0:       sel = acfr_pkg::CMD_SEL_D01;
            1:       sel = acfr_pkg::CMD_SEL_D11;
            2:       sel = acfr_pkg::CMD_SEL_D21;
            3:       sel = acfr_pkg::CMD_SEL_D41;
            4:       sel = acfr_pkg::CMD_SEL_D51;
            5:       sel = acfr_pkg::CMD_SEL_D61;
            6:       sel = acfr_pkg::CMD_SEL_D81;
            7, 8, 9: sel = acfr_pkg::CMD_SEL_D71;
            10, 11:  sel = acfr_pkg::CMD_SEL_D31;
            default: sel = plain_byte();
        endcase
        q.push_back(($urandom_range(0, 31) == 0) ? plain_byte() : acfr_pkg::CH_D);
        q.push_back(sel);
        q.push_back(($urandom_range(0, 31) == 0) ? plain_byte() : acfr_pkg::CMD_TAIL);
        for (int k = 0; k < 3; k++)
            q.push_back(($urandom_range(0, 9) == 0) ? plain_byte() : dev_id[k]);
        if (sel == acfr_pkg::CMD_SEL_D71 && $urandom_range(0, 7) != 0) begin
            repeat (3) begin
                case ($urandom_range(0, 4))
                    0:       repeat (4) q.push_back(acfr_pkg::CH_ZERO);
                    1:       repeat (4) q.push_back("F");
                    2:       repeat (4) q.push_back("f");
                    3:       repeat (4) q.push_back(digit_char());
                    default: repeat (4) q.push_back(plain_byte());
                endcase
            end
        end else if (sel == acfr_pkg::CMD_SEL_D31 && $urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 1) == 0) repeat (3) q.push_back(acfr_pkg::CH_ZERO);
            else repeat (3) q.push_back(plain_byte());
        end else begin
            case ($urandom_range(0, 19))
                0, 1:    plen = $urandom_range(9, 52);
                2:       plen = $urandom_range(53, 60);
                default: plen = $urandom_range(0, 8);
            endcase
            repeat (plen) q.push_back(plain_byte());
        end
        if ($urandom_range(0, 19) == 0) q = q[0:$urandom_range(0, 8)];
        return close_with_check(q, ($urandom_range(0, 9) == 0) ? CK_BAD : CK_GOOD);
    endfunction

    task automatic add_row(input string body, input int pad, input t_ck ck, input t_exp exp,
                           input string payload);
        t_frame_row r;
        r.body    = body;
        r.pad     = pad;
        r.ck      = ck;
        r.exp     = exp;
        r.payload = payload;
        frame_table.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $time);
    endtask

    task automatic send_rx(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        burst_left--;
        if (b != acfr_pkg::CH_LF) rx_sent++;
        absorb_rx_byte(b);
    endtask

    task automatic send_frame(input t_bytes q, input bit lf_noise);
        foreach (q[k]) begin
            if (lf_noise && $urandom_range(0, 31) == 0) send_rx(acfr_pkg::CH_LF);
            send_rx(q[k]);
        end
    endtask

    // receiver: rotating ready pattern, reloaded now and then
    always @(posedge i_clk) begin
        if (pat_age == 0) begin
            pat_age   = $urandom_range(16, 64);
            ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF
                        : (8'($urandom) | (8'h01 << $urandom_range(0, 7)));
        end
        pat_age--;
        ready_pat = {ready_pat[0], ready_pat[7:1]};
        i_reply_ready <= ready_pat[0];
    end

    // reply checker and stall watchdog
    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_reply_valid && i_reply_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else if (i_rst_n && o_reply_valid && i_reply_ready) begin
            if (reply_due_q.size() == 0) begin
                report_mismatch("reply transfer with nothing due", o_reply_byte, 8'h00);
            end else begin
                seen_due = reply_due_q.pop_front();
                if (o_reply_byte !== seen_due.data)
                    report_mismatch("reply_byte", o_reply_byte, seen_due.data);
                if (o_reply_last !== seen_due.last)
                    report_mismatch("reply_last", {7'h0, o_reply_last}, {7'h0, seen_due.last});
            end
        end
    end

    initial begin
        t_bytes fq;
        t_bytes rep;
        int     rnd_start;

        clear_frame();
        foreach (dev_id[k]) dev_id[k] = acfr_pkg::CH_ZERO;
        model_muted = 1'b0;

        add_row("0000D01000", 0, CK_GOOD, EXP_TYPED, "0003AB");
        add_row("0000D81000", 0, CK_GOOD, EXP_TYPED, "0003A3");
        add_row("0000D11000", 0, CK_GOOD, EXP_TYPED, "OK");
        add_row("0000D21000", 0, CK_GOOD, EXP_TYPED, "OK");
        add_row("0000D41000", 0, CK_GOOD, EXP_TYPED, "OK");
        add_row("0000D51000", 0, CK_GOOD, EXP_TYPED, "OK");
        add_row("0000D61000", 0, CK_GOOD, EXP_TYPED, "OK");
        add_row("0000D71000", 12, CK_GOOD, EXP_TYPED, "OK");
        add_row("0000D71000FFFF00000000", 0, CK_GOOD, EXP_TYPED, "NO");
        add_row("0000D71000FFFFFFFFFFFF", 0, CK_GOOD, EXP_TYPED, "OK");
        add_row("0000D710000000ffffFFFF", 0, CK_GOOD, EXP_TYPED, "NO");
        // payload absent: only the checksum characters land in the value bytes
        add_row("0000D71000", 0, CK_GOOD, EXP_TYPED, "OK");
        add_row("0000D71000zz#!FFFF0000", 0, CK_GOOD, EXP_MODEL, "");
        add_row("0000D01000", 0, CK_BAD, EXP_NONE, "");
        add_row("0000D010", 0, CK_GOOD, EXP_NONE, "");
        add_row("0000D11AB", 0, CK_GOOD, EXP_NONE, "");
        add_row("0000D01123", 0, CK_GOOD, EXP_NONE, "");
        add_row("0000D91000", 0, CK_GOOD, EXP_NONE, "");
        add_row("0000E01000", 0, CK_GOOD, EXP_NONE, "");
        add_row("", 0, CK_NONE, EXP_NONE, "");
        add_row("00\n00D11000", 0, CK_GOOD, EXP_MODEL, "");
        add_row("0000D11000", 52, CK_GOOD, EXP_TYPED, "OK");
        add_row("0000D11000", 53, CK_GOOD, EXP_NONE, "");
        add_row("\377\177\200\001D81000", 0, CK_GOOD, EXP_MODEL, "");
        add_row("0000D31000ABC", 0, CK_GOOD, EXP_TYPED, "OK");
        add_row("0000D01000", 0, CK_GOOD, EXP_NONE, "");
        add_row("0000D31ABC000", 0, CK_GOOD, EXP_TYPED, "OK");

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (frame_table[r]) begin
            fq = {};
            for (int k = 0; k < frame_table[r].body.len(); k++)
                fq.push_back(frame_table[r].body[k]);
            repeat (frame_table[r].pad) fq.push_back(acfr_pkg::CH_ZERO);
            fq = close_with_check(fq, frame_table[r].ck);
            model_muted = (frame_table[r].exp != EXP_MODEL);
            steady = ($urandom_range(0, 3) == 0);
            send_frame(fq, 1'b0);
            if (frame_table[r].exp == EXP_TYPED) begin
                rep = {};
                for (int k = 0; k < acfr_pkg::HDR_LEN; k++)
                    rep.push_back(frame_table[r].body[k]);
                for (int k = 0; k < frame_table[r].payload.len(); k++)
                    rep.push_back(frame_table[r].payload[k]);
                seal_and_queue(rep);
            end
        end
        model_muted = 1'b0;

        rnd_start = rx_sent;
        while (rx_sent < rnd_start + RANDOM_BYTES) begin
            steady = ($urandom_range(0, 3) == 0);
            send_frame(random_frame(), 1'b1);
        end
        i_rx_valid <= 1'b0;

        while (reply_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: ascii_frame_checker_responder_unit.f
rtl/acfr_pkg.sv
rtl/acfr_ram.sv
rtl/ascii_frame_checker_responder_unit.sv
dv/ascii_frame_checker_responder_unit_tb.sv
